/* src/vector_regress_out_defines.svh */
// Assertion macros shared by the vector regress-out block.
`ifndef VECTOR_REGRESS_OUT_DEFINES_SVH
`define VECTOR_REGRESS_OUT_DEFINES_SVH
`ifndef SYNTHESIS
`define VRO_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("vector_regress_out assertion failed");
`define VRO_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("vector_regress_out forbidden condition");
`else
`define VRO_ASSERT(lbl, prop)
`define VRO_ASSERT_NEVER(lbl, expr)
`endif
`endif

/* src/vro_pkg.sv */
// Types and constants of the vector regress-out block.
`timescale 1ns / 1ps
package vro_pkg;
	localparam int MAX_VERTICES = 4096;
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = IDX_W + 1;
	localparam int ENTRY_W = 33;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_COMPUTE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [11:0] index;
		logic signed [15:0] value_in;
		logic signed [15:0] curv_in;
		logic excluded;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] curv_out;
		logic signed [15:0] curv_lo;
		logic signed [15:0] curv_hi;
		logic unchanged;
	} out_word_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_SUM, ST_DIVM, ST_DIVC, ST_VAR, ST_DIVK, ST_ADJ, ST_DONE
	} state_t;
endpackage

/* src/vector_regress_out.sv */
// Top level of the vector regress-out block.
//
// channel  direction  handshake             word
// in       input      in_valid/in_ready     vro_pkg::in_word_t
// out      output     out_valid/out_ready   vro_pkg::out_word_t
// cfg      input      cfg_valid/cfg_ready   13-bit vertex_count
//
// Load and no-op results are registered on accept; read goes through ST_RD (one vertex RAM read).
// Compute for n vertices: three passes over the vertex RAM at one entry a cycle
// plus three divisions.
// Without value variance the last division and pass are skipped.
// Input ready drops while an item is at work or a result waits unaccepted.
// Reset clears control state only; the vertex RAM is undefined until loaded.
`timescale 1ns / 1ps
`include "vector_regress_out_defines.svh"
module vector_regress_out (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input vro_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_ready,
	output vro_pkg::out_word_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [12:0] cfg_data
);
	import vro_pkg::*;

	state_t state_q, state_d;
	logic [12:0] cfg_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] issue_q;
	logic in_fire;
	logic issue;
	logic pass_done;

	// vertex RAM signals
	logic ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic signed [15:0] rd_val, rd_curv;
	logic rd_skip;

	// pipeline
	logic v_s1, v_s2;
	logic [IDX_W-1:0] addr_s1, addr_s2;
	logic signed [35:0] dvdv_s2, dvdc_s2;
	logic signed [49:0] p_s2;
	logic signed [15:0] val_s2, curv_s2;

	// accumulators and results
	logic signed [28:0] sv_q, sc_q;
	logic signed [16:0] mv_q, mc_q;
	logic [47:0] len2_q;
	logic signed [47:0] cov_q;
	logic signed [31:0] k_q;
	logic signed [15:0] min_q, max_q;
	logic unchanged_q;
	out_word_t out_q;
	logic out_valid_q;

	// divider
	logic div_start;
	logic [63:0] div_dividend;
	logic [47:0] div_divisor;
	div_stat_t div_stat;
	logic [63:0] div_quo;
	logic mean_neg_q;

	// datapath helpers
	logic signed [17:0] dv, dc;
	logic [47:0] acov;
	logic signed [16:0] quo_signed;
	logic signed [49:0] p_bias;
	logic signed [33:0] p_q16;
	logic signed [34:0] c_wide;
	logic signed [15:0] c_new;
	logic signed [31:0] k_new;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire = in_valid && in_ready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 13'd4096;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	vro_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_val = ram_rdata[32:17];
	assign rd_curv = ram_rdata[16:1];
	assign rd_skip = ram_rdata[0];

	vro_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.stat(div_stat),
		.quotient(div_quo)
	);

	// pass sequencing
	assign issue = ((state_q == ST_SUM) || (state_q == ST_VAR) || (state_q == ST_ADJ))
		&& (issue_q < n_q);
	assign pass_done = (issue_q == n_q) && !v_s1 && !v_s2;
	assign ram_raddr = (state_q == ST_IDLE) ? in_data.index : issue_q[IDX_W-1:0];

	// centered deltas from RAM output
	assign dv = 18'(rd_val) - 18'(mv_q);
	assign dc = 18'(rd_curv) - 18'(mc_q);

	// signed mean from unsigned quotient
	assign quo_signed = mean_neg_q ? -$signed(div_quo[16:0]) : $signed(div_quo[16:0]);

	// slope from quotient of |cov|<<16 / len2, saturated
	always_comb begin
		if (div_quo[63:31] != '0) begin
			k_new = mean_neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			k_new = mean_neg_q ? -$signed({1'b0, div_quo[30:0]})
				: $signed({1'b0, div_quo[30:0]});
		end
	end

	// corrected curvature: truncate k*dv/65536 toward zero, subtract, saturate
	always_comb begin
		p_bias = p_s2 + (p_s2[49] ? 50'sd65535 : 50'sd0);
		p_q16 = p_bias[49:16];
		c_wide = 35'(curv_s2) - 35'(p_q16);
		if (c_wide > 35'sd32767) begin
			c_new = 16'sh7fff;
		end else if (c_wide < -35'sd32768) begin
			c_new = 16'sh8000;
		end else begin
			c_new = c_wide[15:0];
		end
	end

	assign acov = cov_q[47] ? 48'(-cov_q) : 48'(cov_q);

	// RAM write: load words and the adjust pass
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = in_data.index;
		ram_wdata = {in_data.value_in, in_data.curv_in, in_data.excluded};
		if (state_q == ST_ADJ) begin
			ram_we = v_s2;
			ram_waddr = addr_s2;
			ram_wdata = {val_s2, c_new, 1'b0};
		end else if (in_fire && in_data.op == OP_LOAD) begin
			ram_we = 1'b1;
		end
	end

	// next state and divider launch
	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_dividend = {35'd0, sv_q[28] ? 29'(-sv_q) : 29'(sv_q)};
		div_divisor = {35'd0, n_q};
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (in_data.op)
						OP_COMPUTE: state_d = ST_SUM;
						OP_READ: state_d = ST_RD;
						OP_LOAD, OP_NONE: state_d = ST_IDLE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD: state_d = ST_IDLE;
			ST_SUM: begin
				if (pass_done) begin
					div_start = 1'b1;
					state_d = ST_DIVM;
				end
			end
			ST_DIVM: begin
				div_dividend = {35'd0, sc_q[28] ? 29'(-sc_q) : 29'(sc_q)};
				if (div_stat.done) begin
					div_start = 1'b1;
					state_d = ST_DIVC;
				end
			end
			ST_DIVC: begin
				if (div_stat.done) begin
					state_d = ST_VAR;
				end
			end
			ST_VAR: begin
				div_dividend = {acov, 16'd0};
				div_divisor = len2_q;
				if (pass_done) begin
					if (len2_q == '0) begin
						state_d = ST_DONE;
					end else begin
						div_start = 1'b1;
						state_d = ST_DIVK;
					end
				end
			end
			ST_DIVK: begin
				if (div_stat.done) begin
					state_d = ST_ADJ;
				end
			end
			ST_ADJ: begin
				if (pass_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			min_q <= 16'sh7fff;
			max_q <= 16'sh8000;
			unchanged_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				issue_q <= '0;
			end else if (issue) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1 && !rd_skip && ((state_q == ST_VAR) || (state_q == ST_ADJ));
			if (state_q == ST_VAR && pass_done && len2_q == '0) begin
				unchanged_q <= 1'b1;
			end
			if (state_q == ST_DIVK && div_stat.done) begin
				unchanged_q <= 1'b0;
				min_q <= 16'sh7fff;
				max_q <= 16'sh8000;
			end else if (state_q == ST_ADJ && v_s2) begin
				if (c_new < min_q) min_q <= c_new;
				if (c_new > max_q) max_q <= c_new;
			end
			// result register
			if ((in_fire && (in_data.op == OP_LOAD || in_data.op == OP_NONE))
				|| state_q == ST_RD || state_q == ST_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		addr_s1 <= issue_q[IDX_W-1:0];
		addr_s2 <= addr_s1;
		dvdv_s2 <= dv * dv;
		dvdc_s2 <= dv * dc;
		p_s2 <= 50'(k_q) * 50'(dv);
		val_s2 <= rd_val;
		curv_s2 <= rd_curv;
		if (in_fire) begin
			n_q <= (cfg_q == '0) ? CNT_W'(1)
				: (cfg_q > 13'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(cfg_q);
			sv_q <= '0;
			sc_q <= '0;
			len2_q <= '0;
			cov_q <= '0;
		end
		if (state_q == ST_SUM && v_s1 && !rd_skip) begin
			sv_q <= sv_q + 29'(rd_val);
			sc_q <= sc_q + 29'(rd_curv);
		end
		if (state_q == ST_VAR && v_s2) begin
			len2_q <= len2_q + {12'd0, dvdv_s2[35:0]};
			cov_q <= cov_q + 48'(dvdc_s2);
		end
		if (div_start) begin
			mean_neg_q <= (state_q == ST_SUM) ? sv_q[28]
				: (state_q == ST_DIVM) ? sc_q[28] : cov_q[47];
		end
		if (state_q == ST_DIVM && div_stat.done) mv_q <= quo_signed;
		if (state_q == ST_DIVC && div_stat.done) mc_q <= quo_signed;
		if (state_q == ST_DIVK && div_stat.done) k_q <= k_new;
		if (in_fire && (in_data.op == OP_LOAD || in_data.op == OP_NONE)) begin
			out_q <= '{curv_out: 16'sd0, curv_lo: min_q, curv_hi: max_q,
				unchanged: unchanged_q};
		end else if (state_q == ST_RD) begin
			out_q <= '{curv_out: rd_curv, curv_lo: min_q, curv_hi: max_q,
				unchanged: unchanged_q};
		end else if (state_q == ST_DONE) begin
			out_q <= '{curv_out: 16'sd0, curv_lo: min_q, curv_hi: max_q,
				unchanged: unchanged_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// checks
	`VRO_ASSERT(a_ram_write_src, ram_we |-> ((state_q == ST_ADJ) || (in_fire && in_data.op == OP_LOAD)))
	`VRO_ASSERT(a_read_latency, (in_fire && in_data.op == OP_READ) |=> (state_q == ST_RD))
	`VRO_ASSERT_NEVER(a_adj_range, (state_q == ST_ADJ) && v_s2 && ({1'b0, addr_s2} >= n_q))
	`VRO_ASSERT_NEVER(a_div_overlap, div_start && div_stat.busy)
endmodule

/* src/vro_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vro_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/vro_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module vro_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] dividend,
	input logic [47:0] divisor,
	output vro_pkg::div_stat_t stat,
	output logic [63:0] quotient
);
	import vro_pkg::*;

	logic [6:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [47:0] rem_q;
	logic [63:0] quo_q;
	logic [47:0] dsr_q;
	logic [48:0] trial;
	logic [48:0] diff;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[63]};
		diff = trial - {1'b0, dsr_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quo_q holds dividend bits shifting out and quotient bits shifting in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[48]) begin
				rem_q <= diff[47:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial[47:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = quo_q;
endmodule
